// File: rtl/assert_macros.svh
// Assertion macros shared by the polyline proximity warning RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ppw_pkg.sv
// Package for the polyline proximity warning core: widths, types, codes
// and the power-up vertex list. No dependencies.
package ppw_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int CoordW    = 23;
  localparam int DistW     = 23;
  localparam int LevelW    = 8;
  localparam int StepW     = 16;
  localparam int PointsW   = 7;
  localparam int D2W       = 48;
  localparam int CfgW      = 23;
  localparam logic [DistW-1:0] DistSat = {DistW{1'b1}};
  localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t x;
  } vtx_t;

  typedef struct packed {
    vtx_t   a;
    vtx_t   b;
    coord_t px;
    coord_t pz;
  } seg_req_t;

  typedef struct packed {
    logic                shoot;
    logic [LevelW-1:0]   level;
    logic [DistW-1:0]    distance;
  } post_res_t;

  typedef enum logic [1:0] {
    CFG_POINTS = 2'd0,
    CFG_WARN   = 2'd1,
    CFG_SHOOT  = 2'd2,
    CFG_STEP   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LDA, ST_LDB, ST_SEG, ST_PGO, ST_PWAIT
  } core_st_t;

  typedef enum logic [2:0] {
    SG_IDLE, SG_MUL, SG_DECIDE, SG_SQ, SG_DIV, SG_DONE
  } seg_st_t;

  typedef enum logic [2:0] {
    PS_IDLE, PS_SQRT, PS_LVL, PS_DIV, PS_DONE
  } post_st_t;

  function automatic vtx_t mk(input int x, input int z);
    vtx_t v;
    v.x = CoordW'(x);
    v.z = CoordW'(z);
    return v;
  endfunction

  function automatic vtx_t default_vtx(input logic [IdxW-1:0] idx);
    vtx_t v;
    case (idx)
      IdxW'(0):  v = mk(463514, 10242);
      IdxW'(1):  v = mk(447635, 43372);
      IdxW'(2):  v = mk(422854, 80376);
      IdxW'(3):  v = mk(395615, 119266);
      IdxW'(4):  v = mk(353598, 164106);
      IdxW'(5):  v = mk(301474, 210170);
      IdxW'(6):  v = mk(243472, 251699);
      IdxW'(7):  v = mk(204589, 261542);
      IdxW'(8):  v = mk(169986, 281409);
      IdxW'(9):  v = mk(155606, 281640);
      IdxW'(10): v = mk(130105, 262397);
      IdxW'(11): v = mk(86045, 277955);
      IdxW'(12): v = mk(77895, 303924);
      IdxW'(13): v = mk(65749, 307145);
      IdxW'(14): v = mk(32520, 312147);
      IdxW'(15): v = mk(6719, 312634);
      IdxW'(16): v = mk(-74503, 309554);
      IdxW'(17): v = mk(-154066, 327931);
      IdxW'(18): v = mk(-237473, 324286);
      IdxW'(19): v = mk(-314510, 292470);
      IdxW'(20): v = mk(-394557, 255762);
      IdxW'(21): v = mk(-433098, 214094);
      IdxW'(22): v = mk(-496714, 172785);
      IdxW'(23): v = mk(-529550, 103994);
      IdxW'(24): v = mk(-529058, 49632);
      IdxW'(25): v = mk(-510842, -45606);
      IdxW'(26): v = mk(-475081, -80652);
      IdxW'(27): v = mk(-448110, -179147);
      IdxW'(28): v = mk(-378002, -228016);
      IdxW'(29): v = mk(-297092, -306554);
      IdxW'(30): v = mk(-197318, -373503);
      IdxW'(31): v = mk(-62885, -391733);
      IdxW'(32): v = mk(39013, -397528);
      IdxW'(33): v = mk(185182, -383001);
      IdxW'(34): v = mk(389778, -315910);
      IdxW'(35): v = mk(447219, -255278);
      IdxW'(36): v = mk(489909, -187302);
      IdxW'(37): v = mk(481841, -53135);
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/polyline_proximity_warning_core.sv
// Polyline proximity warning core. Input requests either write one vertex
// into the table (tuser[0] = 0) or query a position (tuser[0] = 1).
// A query yields one result: distance to the polyline, warning level and
// shoot flag. A vertex write yields nothing.
// A query walks the segments in turn: 11 multiplier steps, 4 for the
// cross-product square and 48 divide steps per segment in the worst case,
// fewer for segments where the projection is clamped to an end point,
// then square root and level divide. The segment unit is the bottleneck:
// one query at a time, a new request is taken once the result sits in
// the output register.
// Reset clears control state and the configuration registers to their
// defaults; the vertex table reads as the built-in list until written.
// While the receiver stalls, a finished result stays in the output
// register and further requests can still be taken and worked on.
// Configuration: cfg_we writes cfg_wdata to register cfg_index.
module polyline_proximity_warning_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // vertex_index[5:0], coord_x[28:6], coord_z[51:29], zeros
  input  logic [1:0]  in_tuser,   // mode[0], god_mode[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // distance[22:0], warn_level[30:23], shoot[31]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_wdata
);

  `include "assert_macros.svh"

  ppw_pkg::core_st_t st_r, st_nxt;
  logic [ppw_pkg::PointsW-1:0] points_r;
  logic [ppw_pkg::DistW-1:0]   warn_r, shoot_r;
  logic [ppw_pkg::StepW-1:0]   step_r;
  logic [ppw_pkg::CntW-1:0]    n_r, n_cur;
  logic [ppw_pkg::IdxW-1:0]    i_r, rd_addr;
  ppw_pkg::coord_t             px_r, pz_r, in_x, in_z;
  logic                        god_r, in_acc, is_query, short_q, rd_en;
  ppw_pkg::vtx_t               a_r, rd_data, wr_data;
  ppw_pkg::seg_req_t           seg_req;
  logic                        seg_done, post_vld, post_ack, last_seg;
  logic [ppw_pkg::D2W-1:0]     seg_d2, best_r;
  logic                        best_vld_r;
  ppw_pkg::post_res_t          post_res;
  logic                        out_tvalid_r;
  logic [31:0]                 out_tdata_r;

  assign in_tready = (st_r == ppw_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_query  = in_tuser[0];
  assign in_x      = in_tdata[28:6];
  assign in_z      = in_tdata[51:29];
  assign n_cur     = (points_r > ppw_pkg::PointsW'(ppw_pkg::MaxPoints))
                     ? ppw_pkg::CntW'(ppw_pkg::MaxPoints) : ppw_pkg::CntW'(points_r);
  assign short_q   = (in_x == '0 && in_z == '0) || (n_cur < ppw_pkg::CntW'(2));
  assign last_seg  = (ppw_pkg::CntW'(i_r) == n_r - ppw_pkg::CntW'(1));
  assign post_ack  = (st_r == ppw_pkg::ST_PWAIT) && post_vld && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= ppw_pkg::PointsW'(38);
      warn_r   <= ppw_pkg::DistW'(9600);
      shoot_r  <= ppw_pkg::DistW'(5200);
      step_r   <= ppw_pkg::StepW'(440);
    end else if (cfg_we) begin
      case (cfg_index)
        ppw_pkg::CFG_POINTS: points_r <= cfg_wdata[ppw_pkg::PointsW-1:0];
        ppw_pkg::CFG_WARN:   warn_r   <= cfg_wdata;
        ppw_pkg::CFG_SHOOT:  shoot_r  <= cfg_wdata;
        ppw_pkg::CFG_STEP:   step_r   <= cfg_wdata[ppw_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ppw_pkg::ST_IDLE: begin
        if (in_acc && is_query) st_nxt = short_q ? ppw_pkg::ST_PGO : ppw_pkg::ST_LDA;
      end
      ppw_pkg::ST_LDA:   st_nxt = ppw_pkg::ST_LDB;
      ppw_pkg::ST_LDB:   st_nxt = ppw_pkg::ST_SEG;
      ppw_pkg::ST_SEG: begin
        if (seg_done) st_nxt = last_seg ? ppw_pkg::ST_PGO : ppw_pkg::ST_LDB;
      end
      ppw_pkg::ST_PGO:   st_nxt = ppw_pkg::ST_PWAIT;
      ppw_pkg::ST_PWAIT: if (post_ack) st_nxt = ppw_pkg::ST_IDLE;
      default:           st_nxt = ppw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (st_r)
      ppw_pkg::ST_IDLE: rd_en = in_acc && is_query;
      ppw_pkg::ST_LDA:  begin rd_en = 1'b1; rd_addr = ppw_pkg::IdxW'(1); end
      ppw_pkg::ST_SEG:  begin rd_en = seg_done && !last_seg; rd_addr = i_r + 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ppw_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ppw_pkg::ST_IDLE: begin
        px_r       <= in_x;
        pz_r       <= in_z;
        god_r      <= in_tuser[1];
        n_r        <= n_cur;
        best_vld_r <= 1'b0;
      end
      ppw_pkg::ST_LDA: begin
        a_r <= rd_data;
        i_r <= ppw_pkg::IdxW'(1);
      end
      ppw_pkg::ST_LDB: a_r <= rd_data;
      ppw_pkg::ST_SEG: begin
        if (seg_done) begin
          if (!best_vld_r || seg_d2 < best_r) best_r <= seg_d2;
          best_vld_r <= 1'b1;
          if (!last_seg) i_r <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_data.x  = in_x;
  assign wr_data.z  = in_z;
  assign seg_req.a  = a_r;
  assign seg_req.b  = rd_data;
  assign seg_req.px = px_r;
  assign seg_req.pz = pz_r;

  ppw_vtx_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && !is_query),
    .wr_addr (in_tdata[ppw_pkg::IdxW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppw_seg_unit u_seg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ppw_pkg::ST_LDB),
    .req   (seg_req),
    .done  (seg_done),
    .d2    (seg_d2)
  );

  ppw_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (st_r == ppw_pkg::ST_PGO),
    .d2         (best_r),
    .d2_vld     (best_vld_r),
    .god        (god_r),
    .warn       (warn_r),
    .shoot_dist (shoot_r),
    .step       (step_r),
    .ack        (post_ack),
    .res_vld    (post_vld),
    .res        (post_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (post_ack) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_ack) out_tdata_r <= {post_res.shoot, post_res.level, post_res.distance};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `PPW_ASSERT(a_seg_done_in_seg, seg_done |-> (st_r == ppw_pkg::ST_SEG), "segment result outside walk")
  `PPW_ASSERT(a_post_vld_waits, post_vld |-> (st_r == ppw_pkg::ST_PWAIT), "post result while not waiting")
  `PPW_ASSERT(a_query_busy, (in_acc && is_query) |=> (st_r != ppw_pkg::ST_IDLE), "query did not start")
  `PPW_ASSERT_ALWAYS(a_rst_out, (!rst_n) |=> !out_tvalid, "output valid after reset")

endmodule

// File: rtl/ppw_vtx_mem.sv
// Vertex table: single-port-write, registered-read memory with per-entry
// valid bits; unwritten entries read as the power-up list. Uses ppw_pkg.
module ppw_vtx_mem (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [ppw_pkg::IdxW-1:0] wr_addr,
  input  ppw_pkg::vtx_t            wr_data,
  input  logic                     rd_en,
  input  logic [ppw_pkg::IdxW-1:0] rd_addr,
  output ppw_pkg::vtx_t            rd_data
);

  ppw_pkg::vtx_t                   mem_r [ppw_pkg::MaxPoints];
  logic [ppw_pkg::MaxPoints-1:0]   vld_r;
  ppw_pkg::vtx_t                   rdat_r;
  logic [ppw_pkg::IdxW-1:0]        raddr_r;
  logic                            rhit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdat_r  <= mem_r[rd_addr];
      raddr_r <= rd_addr;
      rhit_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rhit_r ? rdat_r : ppw_pkg::default_vtx(raddr_r);

endmodule

// File: rtl/ppw_seg_unit.sv
// Squared distance from a point to one clamped segment: a shared 25x25
// multiplier sequence, then, for an unclamped projection, a radix-2 divide. Uses ppw_pkg.
module ppw_seg_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  ppw_pkg::seg_req_t       req,
  output logic                    done,
  output logic [ppw_pkg::D2W-1:0] d2
);

  localparam int OpW = ppw_pkg::CoordW + 2;
  localparam int PW  = 2 * OpW;
  localparam int NW  = 2 * ppw_pkg::D2W;
  localparam int HW  = ppw_pkg::D2W / 2;
  localparam logic [3:0] MulLast = 4'd10;
  localparam logic [3:0] SqLast  = 4'd3;
  localparam logic [5:0] DivLast = 6'(ppw_pkg::D2W - 1);

  ppw_pkg::seg_st_t st_r, st_nxt;
  logic [3:0]              step_r;
  logic [5:0]              cnt_r;
  logic signed [OpW-1:0]   dx_r, dz_r, wx_r, wz_r, ex_r, ez_r;
  logic signed [OpW-1:0]   ma, mb;
  logic signed [PW-1:0]    prod_r, len2_r, dot_r, c_r, w2_r, e2_r, cabs;
  logic [ppw_pkg::D2W-1:0] mag_r, q_r, rem_r, d2_r, q_nxt;
  logic [NW-1:0]           num_r, numf;
  logic [ppw_pkg::D2W:0]   trem;
  logic                    qbit;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ppw_pkg::SG_IDLE:   if (start) st_nxt = ppw_pkg::SG_MUL;
      ppw_pkg::SG_MUL:    if (step_r == MulLast) st_nxt = ppw_pkg::SG_DECIDE;
      ppw_pkg::SG_DECIDE: begin
        if (len2_r == '0 || dot_r[PW-1] || dot_r == '0 || dot_r >= len2_r)
          st_nxt = ppw_pkg::SG_DONE;
        else st_nxt = ppw_pkg::SG_SQ;
      end
      ppw_pkg::SG_SQ:     if (step_r == SqLast) st_nxt = ppw_pkg::SG_DIV;
      ppw_pkg::SG_DIV:    if (cnt_r == DivLast) st_nxt = ppw_pkg::SG_DONE;
      ppw_pkg::SG_DONE:   st_nxt = ppw_pkg::SG_IDLE;
      default:            st_nxt = ppw_pkg::SG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ppw_pkg::SG_IDLE;
    else        st_r <= st_nxt;
  end

  // multiplier operand select
  always_comb begin
    ma = dx_r;
    mb = dx_r;
    if (st_r == ppw_pkg::SG_SQ) begin
      ma = OpW'({1'b0, mag_r[HW-1:0]});
      mb = OpW'({1'b0, mag_r[HW-1:0]});
      case (step_r)
        4'd1:    ma = OpW'({1'b0, mag_r[ppw_pkg::D2W-1:HW]});
        4'd2: begin
          ma = OpW'({1'b0, mag_r[ppw_pkg::D2W-1:HW]});
          mb = OpW'({1'b0, mag_r[ppw_pkg::D2W-1:HW]});
        end
        default: ;
      endcase
    end else begin
      case (step_r)
        4'd1:    begin ma = dz_r; mb = dz_r; end
        4'd2:    begin ma = wx_r; mb = dx_r; end
        4'd3:    begin ma = wz_r; mb = dz_r; end
        4'd4:    begin ma = wx_r; mb = dz_r; end
        4'd5:    begin ma = wz_r; mb = dx_r; end
        4'd6:    begin ma = wx_r; mb = wx_r; end
        4'd7:    begin ma = wz_r; mb = wz_r; end
        4'd8:    begin ma = ex_r; mb = ex_r; end
        4'd9:    begin ma = ez_r; mb = ez_r; end
        default: ;
      endcase
    end
  end

  assign cabs  = c_r[PW-1] ? -c_r : c_r;
  assign numf  = num_r + (NW'(prod_r) << ppw_pkg::D2W);
  assign trem  = {rem_r, q_r[ppw_pkg::D2W-1]};
  assign qbit  = (trem >= (ppw_pkg::D2W+1)'(len2_r));
  assign q_nxt = {q_r[ppw_pkg::D2W-2:0], qbit};

  always_ff @(posedge clk) begin
    case (st_r)
      ppw_pkg::SG_IDLE: begin
        step_r <= '0;
        dx_r <= OpW'(req.b.x) - OpW'(req.a.x);
        dz_r <= OpW'(req.b.z) - OpW'(req.a.z);
        wx_r <= OpW'(req.px) - OpW'(req.a.x);
        wz_r <= OpW'(req.pz) - OpW'(req.a.z);
        ex_r <= OpW'(req.px) - OpW'(req.b.x);
        ez_r <= OpW'(req.pz) - OpW'(req.b.z);
      end
      ppw_pkg::SG_MUL: begin
        prod_r <= ma * mb;
        step_r <= step_r + 4'd1;
        case (step_r)
          4'd1:    len2_r <= prod_r;
          4'd2:    len2_r <= len2_r + prod_r;
          4'd3:    dot_r  <= prod_r;
          4'd4:    dot_r  <= dot_r + prod_r;
          4'd5:    c_r    <= prod_r;
          4'd6:    c_r    <= c_r - prod_r;
          4'd7:    w2_r   <= prod_r;
          4'd8:    w2_r   <= w2_r + prod_r;
          4'd9:    e2_r   <= prod_r;
          4'd10:   e2_r   <= e2_r + prod_r;
          default: ;
        endcase
      end
      ppw_pkg::SG_DECIDE: begin
        step_r <= '0;
        mag_r  <= cabs[ppw_pkg::D2W-1:0];
        if (len2_r == '0 || dot_r[PW-1] || dot_r == '0) d2_r <= w2_r[ppw_pkg::D2W-1:0];
        else if (dot_r >= len2_r)                       d2_r <= e2_r[ppw_pkg::D2W-1:0];
      end
      ppw_pkg::SG_SQ: begin
        prod_r <= ma * mb;
        step_r <= step_r + 4'd1;
        case (step_r)
          4'd1: num_r <= NW'(prod_r);
          4'd2: num_r <= num_r + (NW'(prod_r) << (HW + 1));
          4'd3: begin
            num_r <= numf;
            rem_r <= numf[NW-1:ppw_pkg::D2W];
            q_r   <= numf[ppw_pkg::D2W-1:0];
            cnt_r <= '0;
          end
          default: ;
        endcase
      end
      ppw_pkg::SG_DIV: begin
        rem_r <= qbit ? ppw_pkg::D2W'(trem - (ppw_pkg::D2W+1)'(len2_r))
                      : trem[ppw_pkg::D2W-1:0];
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DivLast) d2_r <= q_nxt;
      end
      default: ;
    endcase
  end

  assign done = (st_r == ppw_pkg::SG_DONE);
  assign d2   = d2_r;

endmodule

// File: rtl/ppw_post.sv
// Distance and level stage: bit-serial integer square root, then a
// restoring divide for the warning level; the shoot check is a compare. Uses ppw_pkg.
module ppw_post (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ppw_pkg::D2W-1:0]   d2,
  input  logic                      d2_vld,
  input  logic                      god,
  input  logic [ppw_pkg::DistW-1:0] warn,
  input  logic [ppw_pkg::DistW-1:0] shoot_dist,
  input  logic [ppw_pkg::StepW-1:0] step,
  input  logic                      ack,
  output logic                      res_vld,
  output ppw_pkg::post_res_t        res
);

  localparam int RW = ppw_pkg::D2W / 2;
  localparam int DW = ppw_pkg::DistW;
  localparam int SW = ppw_pkg::StepW;
  localparam logic [4:0] SqrtLast = 5'(RW - 1);
  localparam logic [4:0] DivLast  = 5'(DW - 1);

  ppw_pkg::post_st_t st_r, st_nxt;
  logic [4:0]          cnt_r;
  logic [ppw_pkg::D2W-1:0] v_r;
  logic [RW-1:0]       root_r;
  logic [RW+1:0]       srem_r;
  logic [RW+2:0]       st_t, st_trial;
  logic                sbit;
  logic [DW-1:0]       dist_r, dq_r, dq_nxt;
  logic [SW-1:0]       drem_r, dv_r;
  logic [SW:0]         dt;
  logic                dbit;
  logic                god_r;
  ppw_pkg::post_res_t  res_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ppw_pkg::PS_IDLE: begin
        if (start) st_nxt = d2_vld ? ppw_pkg::PS_SQRT : ppw_pkg::PS_LVL;
      end
      ppw_pkg::PS_SQRT: if (cnt_r == SqrtLast) st_nxt = ppw_pkg::PS_LVL;
      ppw_pkg::PS_LVL:  st_nxt = (dist_r <= warn) ? ppw_pkg::PS_DIV : ppw_pkg::PS_DONE;
      ppw_pkg::PS_DIV:  if (cnt_r == DivLast) st_nxt = ppw_pkg::PS_DONE;
      ppw_pkg::PS_DONE: if (ack) st_nxt = ppw_pkg::PS_IDLE;
      default:          st_nxt = ppw_pkg::PS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ppw_pkg::PS_IDLE;
    else        st_r <= st_nxt;
  end

  assign st_t     = {srem_r[RW:0], v_r[ppw_pkg::D2W-1 -: 2]};
  assign st_trial = (RW+3)'({root_r, 2'b01});
  assign sbit     = (st_t >= st_trial);
  assign dt       = {drem_r, dq_r[DW-1]};
  assign dbit     = (dt >= (SW+1)'(dv_r));
  assign dq_nxt   = {dq_r[DW-2:0], dbit};

  always_ff @(posedge clk) begin
    case (st_r)
      ppw_pkg::PS_IDLE: begin
        cnt_r  <= '0;
        god_r  <= god;
        v_r    <= d2;
        root_r <= '0;
        srem_r <= '0;
        dist_r <= ppw_pkg::DistSat;
      end
      ppw_pkg::PS_SQRT: begin
        cnt_r  <= cnt_r + 5'd1;
        v_r    <= v_r << 2;
        root_r <= {root_r[RW-2:0], sbit};
        srem_r <= sbit ? (RW+2)'(st_t - st_trial) : st_t[RW+1:0];
        if (cnt_r == SqrtLast) begin
          if ({root_r[RW-2:0], sbit} > RW'(ppw_pkg::DistSat)) dist_r <= ppw_pkg::DistSat;
          else dist_r <= DW'({root_r[RW-2:0], sbit});
        end
      end
      ppw_pkg::PS_LVL: begin
        cnt_r          <= '0;
        dq_r           <= warn - dist_r;
        drem_r         <= '0;
        dv_r           <= (step == '0) ? SW'(1) : step;
        res_r.distance <= dist_r;
        res_r.level    <= '0;
        res_r.shoot    <= (dist_r <= warn) && (dist_r <= shoot_dist) && !god_r;
      end
      ppw_pkg::PS_DIV: begin
        cnt_r  <= cnt_r + 5'd1;
        dq_r   <= dq_nxt;
        drem_r <= dbit ? SW'(dt - (SW+1)'(dv_r)) : dt[SW-1:0];
        if (cnt_r == DivLast) begin
          if (dq_nxt == '0)                  res_r.level <= ppw_pkg::LevelW'(1);
          else if (dq_nxt > DW'(ppw_pkg::LevelMax)) res_r.level <= ppw_pkg::LevelMax;
          else                               res_r.level <= dq_nxt[ppw_pkg::LevelW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign res_vld = (st_r == ppw_pkg::PS_DONE);
  assign res     = res_r;

endmodule

// File: tb/sv/tb_polyline_proximity_warning_core.sv
// Testbench for polyline_proximity_warning_core: vertex writes and position
// queries with random idling, results checked against an in-bench predictor.
// Depends on ppw_pkg and the core RTL only.
module tb_polyline_proximity_warning_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [22:0] distance;
    logic [7:0]  level;
    logic        shoot;
  } prox_res_t;

  class proximity_scoreboard;
    longint vx[ppw_pkg::MaxPoints];
    longint vz[ppw_pkg::MaxPoints];
    int unsigned n_points, warn_d, shoot_d, step_d;
    prox_res_t due_q[$];
    int errors;

    function void reset_state();
      ppw_pkg::vtx_t v;
      for (int i = 0; i < ppw_pkg::MaxPoints; i++) begin
        v = ppw_pkg::default_vtx(ppw_pkg::IdxW'(i));
        vx[i] = v.x;
        vz[i] = v.z;
      end
      n_points = 38;
      warn_d = 9600;
      shoot_d = 5200;
      step_d = 440;
      errors = 0;
    endfunction

    function void write_reg(ppw_pkg::cfg_idx_t idx, logic [22:0] val);
      case (idx)
        ppw_pkg::CFG_POINTS: n_points = val[6:0];
        ppw_pkg::CFG_WARN:   warn_d = val;
        ppw_pkg::CFG_SHOOT:  shoot_d = val;
        ppw_pkg::CFG_STEP:   step_d = val[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned seg_dist2(longint ax, longint az, longint bx, longint bz,
                                        longint px, longint pz);
      longint dx, dz, wx, wz, len2, dot, c, ex, ez;
      logic [127:0] cc;
      dx = bx - ax; dz = bz - az;
      wx = px - ax; wz = pz - az;
      len2 = dx * dx + dz * dz;
      dot = wx * dx + wz * dz;
      if (len2 == 0 || dot <= 0) return wx * wx + wz * wz;
      if (dot >= len2) begin
        ex = px - bx; ez = pz - bz;
        return ex * ex + ez * ez;
      end
      c = wx * dz - wz * dx;
      if (c < 0) c = -c;
      cc = 128'(c) * 128'(c);
      cc = cc / 128'(len2);
      return cc[63:0];
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
        if (v >= res + bits) begin
          v -= res + bits;
          res = (res >> 1) + bits;
        end else begin
          res >>= 1;
        end
        bits >>= 2;
      end
      return res;
    endfunction

    function void note_request(logic mode, logic [5:0] idx, ppw_pkg::coord_t x,
                               ppw_pkg::coord_t z, logic god);
      prox_res_t r;
      longint unsigned best, d2, dval, lvl, stp;
      int unsigned n;
      if (!mode) begin
        vx[idx] = x;
        vz[idx] = z;
        return;
      end
      dval = ppw_pkg::DistSat;
      lvl = 0;
      r.shoot = 0;
      if (!(x == 0 && z == 0)) begin
        n = (n_points > ppw_pkg::MaxPoints) ? ppw_pkg::MaxPoints : n_points;
        best = '1;
        for (int i = 0; i + 1 < n; i++) begin
          d2 = seg_dist2(vx[i], vz[i], vx[i+1], vz[i+1], x, z);
          if (d2 < best) best = d2;
        end
        if (best != '1) begin
          dval = int_sqrt(best);
          if (dval > ppw_pkg::DistSat) dval = ppw_pkg::DistSat;
        end
      end
      if (dval <= warn_d) begin
        stp = step_d ? step_d : 1;
        lvl = (warn_d - dval) / stp;
        if (lvl == 0) lvl = 1;
        if (lvl > 255) lvl = 255;
        if (dval <= shoot_d && !god) r.shoot = 1;
      end
      r.distance = dval[22:0];
      r.level = lvl[7:0];
      due_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] d);
      prox_res_t e;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = due_q.pop_front();
      if (d[22:0] !== e.distance || d[30:23] !== e.level || d[31] !== e.shoot) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp dist %0d lvl %0d shoot %0d, got dist %0d lvl %0d shoot %0d",
                   e.distance, e.level, e.shoot, d[22:0], d[30:23], d[31]);
      end
    endfunction
  endclass

  localparam longint unsigned CycleLimit = 30_000_000;
  localparam logic [6:0] PtsSet[8] = '{7'd2, 7'd64, 7'd0, 7'd5, 7'd127, 7'd1, 7'd9, 7'd3};
  localparam logic [22:0] WarnSet[8] = '{23'h7FFFFF, 23'd0, 23'd20000, 23'd60000, 23'd3000,
                                         23'h7FFFFF, 23'd100000, 23'd9600};
  localparam logic [22:0] ShootSet[8] = '{23'h7FFFFF, 23'd0, 23'd8000, 23'd30000, 23'd0,
                                          23'd1000, 23'h7FFFFF, 23'd5200};
  localparam logic [15:0] StepSet[8] = '{16'd1, 16'd0, 16'hFFFF, 16'd100, 16'd7, 16'd1,
                                         16'd3000, 16'd440};

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [55:0] in_tdata;
  logic [1:0] in_tuser, cfg_index;
  logic [31:0] out_tdata;
  logic [22:0] cfg_wdata;
  longint unsigned cycles;
  bit no_gaps;
  int rx_hold;

  proximity_scoreboard sb;

  polyline_proximity_warning_core dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      g = pick_gap();
      out_tready <= (g == 0);
      rx_hold = (g > 0) ? g - 1 : 0;
    end
  end

  task automatic send_request(logic mode, logic [5:0] idx, ppw_pkg::coord_t x,
                              ppw_pkg::coord_t z, logic god);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, z, x, idx};
    in_tuser <= {god, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, idx, x, z, god);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(ppw_pkg::cfg_idx_t idx, logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic ppw_pkg::coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ppw_pkg::coord_t'($urandom);
    if (r < 8) return ppw_pkg::coord_t'($signed($urandom_range(0, 8191)) - 4096);
    return (r == 8) ? ppw_pkg::coord_t'(-4194304) : ppw_pkg::coord_t'(4194303);
  endfunction

  task automatic random_item();
    int n, k, sh;
    ppw_pkg::coord_t x, z;
    n = (sb.n_points > ppw_pkg::MaxPoints) ? ppw_pkg::MaxPoints : sb.n_points;
    if (n < 2) n = 2;
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, n - 1);
        send_request(1'b0, 6'(k), ppw_pkg::coord_t'(sb.vx[k-1]),
                     ppw_pkg::coord_t'(sb.vz[k-1]), 1'($urandom));
      end else begin
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        x = ($urandom_range(0, 1)) ? rand_coord() : ppw_pkg::coord_t'($signed($urandom) >>> 12);
        z = ($urandom_range(0, 1)) ? rand_coord() : ppw_pkg::coord_t'($signed($urandom) >>> 12);
        send_request(1'b0, 6'(k), x, z, 1'($urandom));
      end
    end else begin
      k = $urandom_range(0, n - 1);
      sh = $urandom_range(0, 15);
      x = ppw_pkg::coord_t'(sb.vx[k] + (longint'($signed($urandom)) >>> (20 + sh)));
      z = ppw_pkg::coord_t'(sb.vz[k] + (longint'($signed($urandom)) >>> (20 + sh)));
      case ($urandom_range(0, 9))
        0: begin x = rand_coord(); z = rand_coord(); end
        1: begin x = '0; z = '0; end
        default: ;
      endcase
      send_request(1'b1, 6'($urandom), x, z, 1'($urandom));
    end
  endtask

  initial begin
    int items;
    sb = new();
    sb.reset_state();
    cycles = 0;
    no_gaps = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 0;
    cfg_index = ppw_pkg::CFG_POINTS;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default polyline
    send_request(1'b1, 6'd0, 23'sd0, 23'sd0, 1'b0);
    send_request(1'b1, 6'h3F, 23'sd463514, 23'sd10242, 1'b0);
    send_request(1'b1, 6'd0, 23'sd463514, 23'sd10242, 1'b1);
    send_request(1'b1, 6'd0, 23'sd455000, 23'sd28000, 1'b0);
    send_request(1'b1, 6'd0, 23'sd400000, 23'sd100000, 1'b0);
    send_request(1'b1, 6'd0, ppw_pkg::coord_t'(-4194304), ppw_pkg::coord_t'(-4194304), 1'b0);
    send_request(1'b1, 6'd0, 23'sd4194303, 23'sd4194303, 1'b1);
    send_request(1'b1, 6'd0, 23'sd1, 23'sd0, 1'b0);
    send_request(1'b0, 6'd1, 23'sd463514, 23'sd10242, 1'b0);  // zero-length segment
    send_request(1'b1, 6'd0, 23'sd463600, 23'sd10300, 1'b0);
    send_request(1'b0, 6'd63, ppw_pkg::coord_t'(-4194304), 23'sd4194303, 1'b1);
    send_request(1'b0, 6'd0, 23'sd4194303, ppw_pkg::coord_t'(-4194304), 1'b0);
    send_request(1'b1, 6'd0, 23'sd4194000, ppw_pkg::coord_t'(-4190000), 1'b0);
    drain();
    write_cfg(ppw_pkg::CFG_POINTS, 23'd64);
    write_cfg(ppw_pkg::CFG_WARN, 23'h7FFFFF);
    send_request(1'b1, 6'd0, ppw_pkg::coord_t'(-4194304), 23'sd4194303, 1'b0);
    send_request(1'b1, 6'd0, 23'sd0, 23'sd0, 1'b0);
    send_request(1'b1, 6'd0, 23'sd10, 23'sd20, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(ppw_pkg::CFG_POINTS, 23'(PtsSet[ph]));
      write_cfg(ppw_pkg::CFG_WARN, WarnSet[ph]);
      write_cfg(ppw_pkg::CFG_SHOOT, ShootSet[ph]);
      write_cfg(ppw_pkg::CFG_STEP, 23'(StepSet[ph]));
      no_gaps = (ph == 3);
      items = (PtsSet[ph] > 16) ? 50 : 205;
      for (int i = 0; i < items; i++) begin
        random_item();
        if (ph == 5 && i == 60) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.due_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
